// ===== hdl/pta_pkg.sv =====
// package: item types, codes and constants of the priority tile allocator
package pta_pkg;

	localparam int NUM_TILES_DEF = 16;

	localparam logic [2:0] KIND_SET_FRAME = 3'd0;
	localparam logic [2:0] KIND_ACQUIRE   = 3'd1;
	localparam logic [2:0] KIND_RELEASE   = 3'd2;
	localparam logic [2:0] KIND_SWEEP     = 3'd3;
	localparam logic [2:0] KIND_CLEAR     = 3'd4;

	localparam logic [0:0] REG_EVICT_HYST = 1'd0;
	localparam logic [0:0] REG_STALE_AGE  = 1'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] owner_id;
		logic [15:0] priority_req;
		logic [31:0] frame;
		logic [31:0] retention;
	} req_t;

	typedef struct packed {
		logic        success;
		logic        reused;
		logic        evicted;
		logic [3:0]  tile_index;
		logic [31:0] evicted_owner;
		logic [4:0]  allocated_count;
	} rsp_t;

	// one tile entry as seen by the scan unit
	typedef struct packed {
		logic        valid;
		logic [31:0] owner;
		logic [15:0] prio;
		logic [31:0] last_used;
	} tile_t;

	// scan result handed back to the sequencer
	typedef struct packed {
		logic owner_hit;
		logic free_hit;
		logic victim_hit;
	} scan_flags_t;

endpackage

// ===== hdl/pta_scan.sv =====
// shared compare unit: one tile per cycle while en is high, tracks owner match, first free and best victim
module pta_scan #(
	parameter int NUM_TILES = pta_pkg::NUM_TILES_DEF,
	localparam int IW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 en,
	input  logic [IW-1:0]        idx,
	input  pta_pkg::tile_t       tile,
	input  logic [31:0]          owner,
	output pta_pkg::scan_flags_t flags,
	output logic [IW-1:0]        owner_idx,
	output logic [IW-1:0]        free_idx,
	output logic [IW-1:0]        victim_idx,
	output pta_pkg::tile_t       victim
);

	logic better;

	always_comb begin
		better = !flags.victim_hit
			|| tile.prio < victim.prio
			|| (tile.prio == victim.prio && (tile.last_used < victim.last_used
			|| (tile.last_used == victim.last_used && tile.owner < victim.owner)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags <= '0;
		end else if (clr) begin
			flags <= '0;
		end else if (en) begin
			if (tile.valid && tile.owner == owner && owner != '0 && !flags.owner_hit)
				flags.owner_hit <= 1'b1;
			if (!tile.valid && !flags.free_hit)
				flags.free_hit <= 1'b1;
			if (tile.valid && better)
				flags.victim_hit <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tile.valid && tile.owner == owner && owner != '0 && !flags.owner_hit)
				owner_idx <= idx;
			if (!tile.valid && !flags.free_hit)
				free_idx <= idx;
			if (tile.valid && better) begin
				victim_idx <= idx;
				victim     <= tile;
			end
		end
	end

endmodule

// ===== hdl/priority_tile_allocator_unit.sv =====
// top level: tile table, sequencer and configuration registers
// flow to the done strobe: set frame and unused kinds go straight to S_DONE, sweep and clear
// make one S_WRITE pass, acquire and release make an S_SCAN pass, then S_DEC and an S_WRITE pass
// the scan and write passes visit one tile per cycle; a new item is taken only back in S_IDLE, after done
// busy is high from acceptance until the done strobe; the result holds until the next acceptance
// reset: tiles free, counts zero, frame zero, evict_hysteresis 0, stale_age 4; receiver cannot stall
module priority_tile_allocator_unit #(
	parameter int NUM_TILES = pta_pkg::NUM_TILES_DEF,
	localparam int IW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1,
	localparam int CW = $clog2(NUM_TILES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  pta_pkg::req_t   req,
	output logic            done,
	output pta_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DEC   = 5'b00100,
		S_WRITE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	pta_pkg::req_t req_q;
	logic [IW-1:0] idx_q;
	logic [7:0]    hyst_q;
	logic [31:0]   stale_q;
	logic [31:0]   frame_q;
	logic [CW-1:0] count_q;

	logic [NUM_TILES-1:0] valid_q;
	logic [31:0] owner_q   [NUM_TILES];
	logic [15:0] prio_q    [NUM_TILES];
	logic [31:0] last_q    [NUM_TILES];
	logic [8:0]  pend_q    [NUM_TILES];

	// decision of the acquire: action codes
	logic          act_q;       // assign tile tgt_q
	logic          clr_pend_q;  // clear pending of all but tgt_q
	logic          bump_q;      // pending of tgt_q goes up
	logic          zero_q;      // pending of tgt_q goes to zero
	logic          rel_q;       // free tgt_q
	logic [IW-1:0] tgt_q;
	pta_pkg::rsp_t rsp_q;

	pta_pkg::tile_t       cur;
	pta_pkg::scan_flags_t flags;
	logic [IW-1:0] owner_idx, free_idx, victim_idx;
	pta_pkg::tile_t victim;
	logic          last_idx;
	logic [31:0]   age;
	logic [8:0]    pend_inc;
	logic          sweep_hit;

	assign cur.valid     = valid_q[idx_q];
	assign cur.owner     = owner_q[idx_q];
	assign cur.prio      = prio_q[idx_q];
	assign cur.last_used = last_q[idx_q];
	assign last_idx      = (idx_q == IW'(NUM_TILES - 1));

	pta_scan #(.NUM_TILES(NUM_TILES)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (state_q == S_IDLE),
		.en         (state_q == S_SCAN),
		.idx        (idx_q),
		.tile       (cur),
		.owner      (req_q.owner_id),
		.flags      (flags),
		.owner_idx  (owner_idx),
		.free_idx   (free_idx),
		.victim_idx (victim_idx),
		.victim     (victim)
	);

	assign age      = frame_q - victim.last_used;
	assign pend_inc = pend_q[victim_idx] + 9'd1;
	assign sweep_hit = cur.valid && req_q.retention != '0
		&& (req_q.frame - cur.last_used) >= req_q.retention;

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp = rsp_q;
		rsp.allocated_count = 5'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q  <= '0;
			stale_q <= 32'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pta_pkg::REG_EVICT_HYST: hyst_q  <= cfg_data[7:0];
				pta_pkg::REG_STALE_AGE:  stale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			frame_q <= '0;
			count_q <= '0;
			valid_q <= '0;
			act_q   <= 1'b0;
			clr_pend_q <= 1'b0;
			bump_q  <= 1'b0;
			zero_q  <= 1'b0;
			rel_q   <= 1'b0;
			for (int i = 0; i < NUM_TILES; i++) begin
				owner_q[i] <= '0;
				prio_q[i]  <= '0;
				last_q[i]  <= '0;
				pend_q[i]  <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						rsp_q <= '0;
						act_q <= 1'b0;
						clr_pend_q <= 1'b0;
						bump_q <= 1'b0;
						zero_q <= 1'b0;
						rel_q  <= 1'b0;
						if (req.kind == pta_pkg::KIND_SET_FRAME) begin
							frame_q <= req.frame;
							state_q <= S_DONE;
						end else if (req.kind == pta_pkg::KIND_ACQUIRE
							|| req.kind == pta_pkg::KIND_RELEASE) begin
							state_q <= S_SCAN;
						end else if (req.kind == pta_pkg::KIND_SWEEP
							|| req.kind == pta_pkg::KIND_CLEAR) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + IW'(1);
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_WRITE;
					if (req_q.kind == pta_pkg::KIND_RELEASE) begin
						if (flags.owner_hit) begin
							rel_q <= 1'b1;
							tgt_q <= owner_idx;
							rsp_q.success <= 1'b1;
						end
					end else if (req_q.owner_id == '0) begin
						// owner zero never acquires
					end else if (flags.owner_hit) begin
						act_q <= 1'b1;
						tgt_q <= owner_idx;
						rsp_q.success <= 1'b1;
						rsp_q.reused  <= 1'b1;
						rsp_q.tile_index <= 4'(owner_idx);
					end else if (flags.free_hit) begin
						act_q <= 1'b1;
						tgt_q <= free_idx;
						rsp_q.success <= 1'b1;
						rsp_q.tile_index <= 4'(free_idx);
					end else if (req_q.priority_req >= victim.prio) begin
						tgt_q <= victim_idx;
						clr_pend_q <= 1'b1;
						if (age <= stale_q && {23'd0, pend_inc} <= {24'd0, hyst_q}) begin
							bump_q <= 1'b1;
						end else begin
							// a stale victim keeps its pending count
							if (age <= stale_q)
								zero_q <= 1'b1;
							act_q  <= 1'b1;
							rsp_q.success <= 1'b1;
							rsp_q.evicted <= 1'b1;
							rsp_q.tile_index <= 4'(victim_idx);
							rsp_q.evicted_owner <= victim.owner;
						end
					end
				end
				S_WRITE: begin
					idx_q <= idx_q + IW'(1);
					if (req_q.kind == pta_pkg::KIND_CLEAR
						|| (req_q.kind == pta_pkg::KIND_SWEEP && sweep_hit)
						|| (rel_q && idx_q == tgt_q)) begin
						if (valid_q[idx_q])
							count_q <= count_q - CW'(1);
						valid_q[idx_q] <= 1'b0;
						owner_q[idx_q] <= '0;
						prio_q[idx_q]  <= '0;
						last_q[idx_q]  <= '0;
						pend_q[idx_q]  <= '0;
					end else if (idx_q == tgt_q && (act_q || bump_q || zero_q)) begin
						if (act_q) begin
							if (!valid_q[idx_q])
								count_q <= count_q + CW'(1);
							valid_q[idx_q] <= 1'b1;
							owner_q[idx_q] <= req_q.owner_id;
							prio_q[idx_q]  <= req_q.priority_req;
							last_q[idx_q]  <= frame_q;
						end
						if (bump_q)
							pend_q[idx_q] <= pend_q[idx_q] + 9'd1;
						else if (zero_q)
							pend_q[idx_q] <= '0;
					end else if (clr_pend_q) begin
						pend_q[idx_q] <= '0;
					end
					if (last_idx) begin
						idx_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
